[rtl/srfr_pkg.sv]
`default_nettype none
package srfr_pkg;

   // frame marker bytes
   localparam logic [7:0] HEAD_BYTE = 8'hAA;
   localparam logic [7:0] DATA_KIND = 8'hC0;
   localparam logic [7:0] CMD_KIND  = 8'hC5;
   localparam logic [7:0] TAIL_BYTE = 8'hAB;

   // frame position codes (index of the next expected frame byte)
   localparam logic [3:0] POS_HUNT  = 4'd0;
   localparam logic [3:0] POS_KIND  = 4'd1;
   localparam logic [3:0] POS_FIRST = 4'd2;
   localparam logic [3:0] POS_LAST_DATA = 4'd7;
   localparam logic [3:0] POS_CHECK = 4'd8;
   localparam logic [3:0] POS_TAIL  = 4'd9;

   // frame byte store: bytes 2..8, checksum in the last slot
   localparam int FRAME_SLOTS = 7;
   localparam logic [2:0] SLOT_FIRST = 3'd0;
   localparam logic [2:0] SLOT_CHECK = 3'd6;

   // configuration register indexes
   localparam logic CSR_EXPECT_DATA_REPLY = 1'b0;
   localparam logic CSR_EXPECTED_COMMAND  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_BAD_TAIL = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM  = 2'd2;

   // work kinds handed from front to back
   typedef enum logic [1:0] {
      OP_FIRST,
      OP_DATA,
      OP_CHECK,
      OP_TAIL
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] slot;
      logic [7:0] rx_byte;
   } entry_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  payload_5;
      logic [7:0]  payload_4;
      logic [7:0]  payload_3;
      logic [7:0]  payload_2;
      logic [7:0]  payload_1;
      logic [7:0]  payload_0;
      logic [15:0] fine_reading;
      logic [15:0] coarse_reading;
   } result_type;

endpackage
`default_nettype wire

[rtl/sensor_reply_frame_receiver_core.sv]
// Sensor reply frame receiver.
// req_*: one received serial byte per transaction; tdata holds the byte.
// csr_*: register writes, always ready. Index 0 selects the reply kind
//   (bit 0 = 1 for measurement replies 0xC0, 0 for command replies 0xC5),
//   index 1 sets the command echo that a command reply must carry.
// rsp_*: one transaction per completed ten-byte frame, carrying status,
//   the six payload bytes and the two 16-bit readings.
// A front stage tracks frame position and checks the header bytes as they
// arrive; accepted frame bytes go through a two-entry queue to a back stage
// that stores them, keeps the checksum and builds the result in an output
// register. Throughput is one byte per cycle while the queue has room;
// rsp_tvalid rises once the back stage takes the tail byte from the queue.
// If rsp_tready stays low, the back stage holds the finished result and
// keeps taking frame bytes; only the next tail byte waits, and once the
// queue fills req_tready drops.
// Reset is synchronous: the receiver returns to hunting for the head byte,
// the checksum clears, the reply kind resets to measurement and the
// expected command to zero.
`default_nettype none
module sensor_reply_frame_receiver_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [1:0] status, [9:2] payload_0, [17:10] payload_1, [25:18] payload_2,
   // [33:26] payload_3, [41:34] payload_4, [49:42] payload_5,
   // [65:50] fine_reading, [81:66] coarse_reading, [87:82] zero
   output logic [87:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [7:0]  csr_data
);

   logic                 q_full;
   logic                 push_valid;
   srfr_pkg::entry_type  push_entry;
   logic                 pop_valid;
   logic                 pop_ready;
   srfr_pkg::entry_type  pop_entry;
   srfr_pkg::result_type res_data;

   srfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   srfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   srfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .res_valid (rsp_tvalid),
      .res_data  (res_data),
      .res_ready (rsp_tready)
   );

   // pack result fields, first field in the low bits
   assign rsp_tdata = {6'd0,
                       res_data.coarse_reading,
                       res_data.fine_reading,
                       res_data.payload_5,
                       res_data.payload_4,
                       res_data.payload_3,
                       res_data.payload_2,
                       res_data.payload_1,
                       res_data.payload_0,
                       res_data.status};

endmodule
`default_nettype wire

[rtl/srfr_front.sv]
`default_nettype none
module srfr_front (
   input  wire                     clock,
   input  wire                     reset,
   // byte input
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire  [7:0]              req_tdata,
   // configuration writes
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire                     csr_index,
   input  wire  [7:0]              csr_data,
   // queue push side
   input  wire                     q_full,
   output logic                    push_valid,
   output srfr_pkg::entry_type     push_entry
);

   logic       expect_data_ff, expect_data_in;
   logic [7:0] command_ff, command_in;
   logic [3:0] pos_ff, pos_in;
   logic       accept;
   logic       need_push;

   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   // configuration registers
   always_comb begin
      expect_data_in = expect_data_ff;
      command_in     = command_ff;
      if (csr_valid) begin
         unique case (csr_index)
            srfr_pkg::CSR_EXPECT_DATA_REPLY: expect_data_in = csr_data[0];
            srfr_pkg::CSR_EXPECTED_COMMAND:  command_in     = csr_data;
            default: ;
         endcase
      end
   end

   // header checks and classification of each byte
   always_comb begin
      pos_in             = pos_ff;
      need_push          = 1'b0;
      push_entry.op      = srfr_pkg::OP_DATA;
      push_entry.slot    = 3'(pos_ff - srfr_pkg::POS_FIRST);
      push_entry.rx_byte = req_tdata;
      if (accept) begin
         priority if (pos_ff == srfr_pkg::POS_KIND) begin
            pos_in = (req_tdata == (expect_data_ff ? srfr_pkg::DATA_KIND : srfr_pkg::CMD_KIND))
                   ? srfr_pkg::POS_FIRST : srfr_pkg::POS_HUNT;
         end else if (pos_ff == srfr_pkg::POS_FIRST) begin
            if (!expect_data_ff && (req_tdata != command_ff)) begin
               pos_in = srfr_pkg::POS_HUNT;
            end else begin
               need_push       = 1'b1;
               push_entry.op   = srfr_pkg::OP_FIRST;
               push_entry.slot = srfr_pkg::SLOT_FIRST;
               pos_in          = pos_ff + 4'd1;
            end
         end else if ((pos_ff > srfr_pkg::POS_FIRST) && (pos_ff <= srfr_pkg::POS_LAST_DATA)) begin
            need_push = 1'b1;
            pos_in    = pos_ff + 4'd1;
         end else if (pos_ff == srfr_pkg::POS_CHECK) begin
            need_push       = 1'b1;
            push_entry.op   = srfr_pkg::OP_CHECK;
            push_entry.slot = srfr_pkg::SLOT_CHECK;
            pos_in          = srfr_pkg::POS_TAIL;
         end else if (pos_ff == srfr_pkg::POS_TAIL) begin
            need_push     = 1'b1;
            push_entry.op = srfr_pkg::OP_TAIL;
            pos_in        = srfr_pkg::POS_HUNT;
         end else begin
            // hunting, also any out-of-range position
            pos_in = (req_tdata == srfr_pkg::HEAD_BYTE) ? srfr_pkg::POS_KIND : srfr_pkg::POS_HUNT;
         end
      end
   end

   assign push_valid = need_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_data_ff <= 1'b1;
         command_ff     <= 8'd0;
         pos_ff         <= srfr_pkg::POS_HUNT;
      end else begin
         expect_data_ff <= expect_data_in;
         command_ff     <= command_in;
         pos_ff         <= pos_in;
      end
   end

endmodule
`default_nettype wire

[rtl/srfr_queue.sv]
`default_nettype none
module srfr_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   input  srfr_pkg::entry_type     push_entry,
   output logic                    full,
   output logic                    pop_valid,
   output srfr_pkg::entry_type     pop_entry,
   input  wire                     pop_ready
);

   srfr_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

[rtl/srfr_back.sv]
`default_nettype none
module srfr_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     pop_valid,
   input  srfr_pkg::entry_type     pop_entry,
   output logic                    pop_ready,
   output logic                    res_valid,
   output srfr_pkg::result_type    res_data,
   input  wire                     res_ready
);

   logic [7:0]           bytes_ff [srfr_pkg::FRAME_SLOTS];
   logic [7:0]           sum_ff, sum_in;
   logic                 valid_ff, valid_in;
   srfr_pkg::result_type result_ff, result_in;
   logic                 out_free;
   logic                 take;
   logic                 store;

   assign out_free  = !valid_ff || res_ready;
   assign pop_ready = (pop_entry.op != srfr_pkg::OP_TAIL) || out_free;
   assign take      = pop_valid && pop_ready;
   assign store     = take && (pop_entry.op != srfr_pkg::OP_TAIL);

   // running checksum and result build
   always_comb begin
      sum_in    = sum_ff;
      valid_in  = valid_ff && !res_ready;
      result_in = result_ff;
      if (take) begin
         unique case (pop_entry.op)
            srfr_pkg::OP_FIRST: sum_in = pop_entry.rx_byte;
            srfr_pkg::OP_DATA:  sum_in = sum_ff + pop_entry.rx_byte;
            srfr_pkg::OP_CHECK: ;
            srfr_pkg::OP_TAIL: begin
               valid_in = 1'b1;
               sum_in   = 8'd0;
               priority if (pop_entry.rx_byte != srfr_pkg::TAIL_BYTE) begin
                  result_in.status = srfr_pkg::STATUS_BAD_TAIL;
               end else if (sum_ff != bytes_ff[srfr_pkg::SLOT_CHECK]) begin
                  result_in.status = srfr_pkg::STATUS_BAD_SUM;
               end else begin
                  result_in.status = srfr_pkg::STATUS_GOOD;
               end
               result_in.payload_0      = bytes_ff[0];
               result_in.payload_1      = bytes_ff[1];
               result_in.payload_2      = bytes_ff[2];
               result_in.payload_3      = bytes_ff[3];
               result_in.payload_4      = bytes_ff[4];
               result_in.payload_5      = bytes_ff[5];
               result_in.fine_reading   = {bytes_ff[1], bytes_ff[0]};
               result_in.coarse_reading = {bytes_ff[3], bytes_ff[2]};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (store) begin
         bytes_ff[pop_entry.slot] <= pop_entry.rx_byte;
      end
   end

   assign res_valid = valid_ff;
   assign res_data  = result_ff;

endmodule
`default_nettype wire

[bench/sensor_reply_frame_receiver_core_tb.sv]
`default_nettype none
module sensor_reply_frame_receiver_core_tb;
   import srfr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [1:0] status, [9:2] payload_0 .. [49:42] payload_5,
   // [65:50] fine_reading, [81:66] coarse_reading, [87:82] zero
   logic [87:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   sensor_reply_frame_receiver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // shared run controls
   bit gaps_on      = 1'b1;
   int stall_cycles = 0;
   int fault_count  = 0;

   // frame tracker state, follows every accepted byte
   logic        trk_data_reply;
   logic [7:0]  trk_command;
   logic [3:0]  trk_pos;
   logic [7:0]  trk_bytes [FRAME_SLOTS];
   logic [7:0]  trk_sum;
   result_type  expected_reports [$];

   // register values as programmed by the stimulus side
   logic        stim_data_reply;
   logic [7:0]  stim_command;

   // run statistics
   int bytes_taken = 0;
   int header_drops = 0;
   int frames_checked = 0;
   int status_seen [3] = '{0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // result sink: random idling, plus a counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles = stall_cycles - 1;
      end else begin
         rsp_tready <= !gaps_on || ($urandom_range(99) >= 31);
      end
   end

   // frame tracker: next position and, on the tail byte, the expected report
   task automatic track_rx_byte(input logic [7:0] b);
      result_type r;
      if (trk_pos == POS_HUNT || trk_pos > POS_TAIL) begin
         trk_pos = (b == HEAD_BYTE) ? POS_KIND : POS_HUNT;
      end else if (trk_pos == POS_KIND) begin
         if (b == (trk_data_reply ? DATA_KIND : CMD_KIND)) begin
            trk_pos = POS_FIRST;
         end else begin
            trk_pos = POS_HUNT;
            header_drops++;
         end
      end else if (trk_pos == POS_FIRST) begin
         if (!trk_data_reply && b != trk_command) begin
            trk_pos = POS_HUNT;
            header_drops++;
         end else begin
            trk_bytes[SLOT_FIRST] = b;
            trk_sum = b;
            trk_pos = POS_FIRST + 4'd1;
         end
      end else if (trk_pos <= POS_CHECK) begin
         trk_bytes[3'(trk_pos - POS_FIRST)] = b;
         if (trk_pos <= POS_LAST_DATA)
            trk_sum = trk_sum + b;
         trk_pos = trk_pos + 4'd1;
      end else begin
         // tail byte closes the frame
         if (b != TAIL_BYTE)
            r.status = STATUS_BAD_TAIL;
         else if (trk_sum != trk_bytes[SLOT_CHECK])
            r.status = STATUS_BAD_SUM;
         else
            r.status = STATUS_GOOD;
         r.payload_0 = trk_bytes[0];
         r.payload_1 = trk_bytes[1];
         r.payload_2 = trk_bytes[2];
         r.payload_3 = trk_bytes[3];
         r.payload_4 = trk_bytes[4];
         r.payload_5 = trk_bytes[5];
         r.fine_reading = {trk_bytes[1], trk_bytes[0]};
         r.coarse_reading = {trk_bytes[3], trk_bytes[2]};
         expected_reports.push_back(r);
         status_seen[r.status]++;
         trk_pos = POS_HUNT;
         trk_sum = 8'd0;
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: report field %s mismatch: expected %h, got %h",
                     $realtime, name, want, got);
      end
   endtask

   // monitor: tracks accepted bytes and register writes, checks reports
   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_EXPECT_DATA_REPLY)
               trk_data_reply = csr_data[0];
            else
               trk_command = csr_data;
         end
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            track_rx_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status         = rsp_tdata[1:0];
            got.payload_0      = rsp_tdata[9:2];
            got.payload_1      = rsp_tdata[17:10];
            got.payload_2      = rsp_tdata[25:18];
            got.payload_3      = rsp_tdata[33:26];
            got.payload_4      = rsp_tdata[41:34];
            got.payload_5      = rsp_tdata[49:42];
            got.fine_reading   = rsp_tdata[65:50];
            got.coarse_reading = rsp_tdata[81:66];
            if (expected_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: unexpected report, tdata %h", $realtime, rsp_tdata);
            end else begin
               want = expected_reports.pop_front();
               frames_checked++;
               compare_field("status", 16'(want.status), 16'(got.status));
               compare_field("payload_0", 16'(want.payload_0), 16'(got.payload_0));
               compare_field("payload_1", 16'(want.payload_1), 16'(got.payload_1));
               compare_field("payload_2", 16'(want.payload_2), 16'(got.payload_2));
               compare_field("payload_3", 16'(want.payload_3), 16'(got.payload_3));
               compare_field("payload_4", 16'(want.payload_4), 16'(got.payload_4));
               compare_field("payload_5", 16'(want.payload_5), 16'(got.payload_5));
               compare_field("fine_reading", want.fine_reading, got.fine_reading);
               compare_field("coarse_reading", want.coarse_reading, got.coarse_reading);
            end
         end
      end
   end

   // offer one byte, with optional idle cycles ahead of it
   task automatic push_byte(input logic [7:0] b);
      while (gaps_on && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // one register write; csr_valid is dropped again before the task returns
   task automatic write_csr(input logic idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_EXPECT_DATA_REPLY)
         stim_data_reply = value[0];
      else
         stim_command = value;
   endtask

   // stop sending, wait for every report, then let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // complete frame for the programmed reply kind, random payload
   task automatic send_reply_frame(input bit bad_sum, input bit bad_tail);
      logic [7:0] body [6];
      logic [7:0] sum;
      logic [7:0] tail;
      sum = 8'd0;
      foreach (body[k]) begin
         body[k] = 8'($urandom_range(255));
         if (k == 0 && !stim_data_reply)
            body[k] = stim_command;
         sum = sum + body[k];
      end
      push_byte(HEAD_BYTE);
      push_byte(stim_data_reply ? DATA_KIND : CMD_KIND);
      foreach (body[k]) push_byte(body[k]);
      push_byte(bad_sum ? sum + 8'($urandom_range(1, 255)) : sum);
      tail = 8'($urandom_range(255));
      if (tail == TAIL_BYTE)
         tail = ~tail;
      push_byte(bad_tail ? tail : TAIL_BYTE);
   endtask

   // wrong kind after a head is dropped, and a head byte as kind is not a new head
   task automatic test_header_sync();
      logic [7:0] seq [13];
      seq = '{HEAD_BYTE, HEAD_BYTE, DATA_KIND,
              HEAD_BYTE, DATA_KIND, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h7F,
              8'hFD, TAIL_BYTE};
      foreach (seq[k]) push_byte(seq[k]);
      wait_idle();
   endtask

   // reply kind changed between the head byte and the kind byte
   task automatic test_register_mid_frame();
      logic [7:0] seq [9];
      seq = '{CMD_KIND, 8'hFF, 8'h00, 8'h01, 8'h02, 8'hFE, 8'h80, 8'h81, TAIL_BYTE};
      push_byte(HEAD_BYTE);
      wait_idle();
      write_csr(CSR_EXPECT_DATA_REPLY, 8'h00);
      write_csr(CSR_EXPECTED_COMMAND, 8'hFF);
      foreach (seq[k]) push_byte(seq[k]);
      wait_idle();
   endtask

   // command mode: measurement kind and wrong command echo are dropped
   task automatic test_command_checks();
      logic [7:0] seq [5];
      seq = '{HEAD_BYTE, DATA_KIND, HEAD_BYTE, CMD_KIND, 8'h00};
      foreach (seq[k]) push_byte(seq[k]);
      wait_idle();
   endtask

   // mostly well-formed frames, some broken headers, truncation and noise
   task automatic run_traffic_phase(input logic data_reply, input logic [7:0] command,
                                    input int byte_budget, input bit with_gaps);
      int start;
      int pick;
      logic [7:0] b;
      wait_idle();
      gaps_on = with_gaps;
      write_csr(CSR_EXPECT_DATA_REPLY, {7'd0, data_reply});
      write_csr(CSR_EXPECTED_COMMAND, command);
      start = bytes_taken;
      while (bytes_taken - start < byte_budget) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_reply_frame($urandom_range(99) < 15, $urandom_range(99) < 15);
         end else if (pick < 80) begin
            // cut-off frame: later bytes fill the rest
            push_byte(HEAD_BYTE);
            push_byte(stim_data_reply ? DATA_KIND : CMD_KIND);
            repeat ($urandom_range(7)) push_byte(8'($urandom_range(255)));
         end else if (pick < 90) begin
            push_byte(HEAD_BYTE);
            if (!stim_data_reply && $urandom_range(1)) begin
               push_byte(CMD_KIND);
               push_byte(stim_command ^ 8'($urandom_range(1, 255)));
            end else begin
               b = 8'($urandom_range(255));
               if (b == (stim_data_reply ? DATA_KIND : CMD_KIND))
                  b = b ^ 8'h01;
               push_byte(b);
            end
         end else begin
            repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(255)));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(1'b1, 8'h00, 300, 1'b1);
      run_traffic_phase(1'b0, 8'hFF, 300, 1'b1);
      run_traffic_phase(1'b0, 8'h00, 300, 1'b0);
      run_traffic_phase(1'b0, 8'($urandom_range(255)), 300, 1'b1);
      run_traffic_phase(1'b1, 8'($urandom_range(255)), 300, 1'b1);
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_output_backpressure();
      wait_idle();
      gaps_on = 1'b1;
      stall_cycles = 400;
      repeat (12) send_reply_frame(1'b0, 1'b0);
      wait_idle();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      csr_valid  = 1'b0;
      csr_index  = 1'b0;
      csr_data   = 8'd0;
      trk_data_reply  = 1'b1;
      trk_command     = 8'd0;
      trk_pos         = POS_HUNT;
      trk_sum         = 8'd0;
      foreach (trk_bytes[k]) trk_bytes[k] = 8'd0;
      stim_data_reply = 1'b1;
      stim_command    = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header_sync();
      test_register_mid_frame();
      test_command_checks();
      test_random_traffic();
      test_output_backpressure();
      wait_idle();

      if (expected_reports.size() != 0) begin
         fault_count++;
         $display("%0d expected reports never arrived", expected_reports.size());
      end
      $display("Run covered %0d serial bytes over both reply kinds, %0d header drops",
               bytes_taken, header_drops);
      $display("Reports checked: %0d (good %0d, bad tail %0d, bad checksum %0d)",
               frames_checked, status_seen[STATUS_GOOD], status_seen[STATUS_BAD_TAIL],
               status_seen[STATUS_BAD_SUM]);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire
